/* design/slx_pkg.sv */
package slx_pkg;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_NUMBER = 3'd1,
        MODE_WORD   = 3'd2,
        MODE_STRING = 3'd3,
        MODE_HELD   = 3'd4
    } lex_mode_t;

    // Token classes
    localparam logic [2:0] CLS_INT    = 3'd0;
    localparam logic [2:0] CLS_FLOAT  = 3'd1;
    localparam logic [2:0] CLS_KEY    = 3'd2;
    localparam logic [2:0] CLS_BOOL   = 3'd3;
    localparam logic [2:0] CLS_IDENT  = 3'd4;
    localparam logic [2:0] CLS_STRING = 3'd5;
    localparam logic [2:0] CLS_OP     = 3'd6;
    localparam logic [2:0] CLS_SYM    = 3'd7;

    // Keyword table: let print if else while func return true false
    localparam int NUM_WORDS  = 9;
    localparam int FIRST_BOOL = 7;
    localparam logic [7:0] KW_TEXT [0:8][0:7] = '{
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [0:8] = '{
        3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd4, 3'd6, 3'd4, 3'd5
    };

    // Character constants
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_POINT = 8'h2E;

    // Result records
    localparam int MAX_RECS = 3;
    localparam int QDEPTH   = 8;
    localparam int QIDX_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_valid;
        logic       token_end;
        logic [2:0] token_class;
        logic       last;
    } rec_t;

endpackage

/* design/slx_core.sv */
module slx_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    char_byte,
    input  logic          end_of_source,
    output logic [1:0]    push_cnt,
    output slx_pkg::rec_t push_rec [slx_pkg::MAX_RECS]
);
    import slx_pkg::*;

    lex_mode_t  mode_reg, mode_next;
    logic [7:0] held_reg, held_next;
    logic       point_reg, point_next;
    logic [8:0] mask_reg, mask_next;
    logic [2:0] len_reg, len_next;

    rec_t       recs [MAX_RECS];
    logic [1:0] n;
    logic       used;

    function automatic rec_t mk(input logic [7:0] b, input logic v, input logic e,
                                input logic [2:0] cls);
        rec_t r;
        r.text_byte   = v ? b : 8'h00;
        r.text_valid  = v;
        r.token_end   = e;
        r.token_class = e ? cls : 3'd0;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_held_op(input logic [7:0] c);
        return (c == "+") || (c == "-") || (c == "!") || (c == "=") ||
               (c == ">") || (c == "<") || (c == "&") || (c == "|");
    endfunction

    function automatic logic pairs_with(input logic [7:0] h, input logic [7:0] c);
        if ((h == "+") || (h == "-") || (h == "&") || (h == "|"))
            return c == h;
        return c == "=";
    endfunction

    // Drop every keyword that no longer matches at this position
    function automatic logic [8:0] match_step(input logic [8:0] mask,
                                              input logic [2:0] pos,
                                              input logic [7:0] c);
        logic [8:0] m;
        m = mask;
        for (int k = 0; k < NUM_WORDS; k++) begin
            if ((pos >= KW_LEN[k]) || (KW_TEXT[k][pos] != c))
                m[k] = 1'b0;
        end
        return m;
    endfunction

    // First full match decides keyword or bool, else identifier
    function automatic logic [2:0] word_class(input logic [8:0] mask,
                                              input logic [2:0] len);
        logic [2:0] cls;
        logic       found;
        cls   = CLS_IDENT;
        found = 1'b0;
        for (int k = 0; k < NUM_WORDS; k++) begin
            if (!found && mask[k] && (KW_LEN[k] == len)) begin
                found = 1'b1;
                cls   = (k < FIRST_BOOL) ? CLS_KEY : CLS_BOOL;
            end
        end
        return cls;
    endfunction

    function automatic rec_t close_rec(input lex_mode_t m, input logic [7:0] h,
                                       input logic p, input logic [8:0] mask,
                                       input logic [2:0] len);
        rec_t r;
        unique case (m)
            MODE_NUMBER: r = mk(8'h00, 1'b0, 1'b1, p ? CLS_FLOAT : CLS_INT);
            MODE_WORD:   r = mk(8'h00, 1'b0, 1'b1, word_class(mask, len));
            MODE_STRING: r = mk(8'h00, 1'b0, 1'b1, CLS_STRING);
            MODE_HELD:   r = mk(h, 1'b1, 1'b1,
                                ((h == "&") || (h == "|")) ? CLS_SYM : CLS_OP);
            default:     r = mk(8'h00, 1'b0, 1'b0, CLS_INT);
        endcase
        return r;
    endfunction

    // Next state and up to three records for the item at the port
    always_comb
    begin
        mode_next  = mode_reg;
        held_next  = held_reg;
        point_next = point_reg;
        mask_next  = mask_reg;
        len_next   = len_reg;
        used       = 1'b0;
        n          = 2'd0;
        for (int i = 0; i < MAX_RECS; i++)
            recs[i] = '0;

        // Continue or close the open token
        unique case (mode_reg)
            MODE_HELD:
            begin
                if (pairs_with(held_reg, char_byte))
                begin
                    recs[0] = mk(held_reg, 1'b1, 1'b0, CLS_INT);
                    recs[1] = mk(char_byte, 1'b1, 1'b1, CLS_OP);
                    n       = 2'd2;
                    used    = 1'b1;
                end
                else
                begin
                    recs[0] = close_rec(mode_reg, held_reg, point_reg, mask_reg, len_reg);
                    n       = 2'd1;
                end
                mode_next  = MODE_IDLE;
                held_next  = 8'h00;
                point_next = 1'b0;
                mask_next  = '0;
                len_next   = '0;
            end
            MODE_NUMBER:
            begin
                if (is_digit(char_byte) || (char_byte == CH_POINT))
                begin
                    if (char_byte == CH_POINT)
                        point_next = 1'b1;
                    recs[0] = mk(char_byte, 1'b1, 1'b0, CLS_INT);
                    n       = 2'd1;
                    used    = 1'b1;
                end
                else
                begin
                    recs[0]    = close_rec(mode_reg, held_reg, point_reg, mask_reg, len_reg);
                    n          = 2'd1;
                    mode_next  = MODE_IDLE;
                    held_next  = 8'h00;
                    point_next = 1'b0;
                    mask_next  = '0;
                    len_next   = '0;
                end
            end
            MODE_WORD:
            begin
                if (is_alpha(char_byte) || is_digit(char_byte))
                begin
                    mask_next = match_step(mask_reg, len_reg, char_byte);
                    if (len_reg != 3'd7)
                        len_next = len_reg + 3'd1;
                    recs[0] = mk(char_byte, 1'b1, 1'b0, CLS_INT);
                    n       = 2'd1;
                    used    = 1'b1;
                end
                else
                begin
                    recs[0]    = close_rec(mode_reg, held_reg, point_reg, mask_reg, len_reg);
                    n          = 2'd1;
                    mode_next  = MODE_IDLE;
                    held_next  = 8'h00;
                    point_next = 1'b0;
                    mask_next  = '0;
                    len_next   = '0;
                end
            end
            MODE_STRING:
            begin
                used    = 1'b1;
                n       = 2'd1;
                if (char_byte == CH_QUOTE)
                begin
                    recs[0]    = close_rec(mode_reg, held_reg, point_reg, mask_reg, len_reg);
                    mode_next  = MODE_IDLE;
                    held_next  = 8'h00;
                    point_next = 1'b0;
                    mask_next  = '0;
                    len_next   = '0;
                end
                else
                begin
                    recs[0] = mk(char_byte, 1'b1, 1'b0, CLS_INT);
                end
            end
            default:
            begin
                mode_next  = MODE_IDLE;
                held_next  = 8'h00;
                point_next = 1'b0;
                mask_next  = '0;
                len_next   = '0;
            end
        endcase

        // Start a new token from this byte when it was not consumed
        if (!used)
        begin
            if (is_space(char_byte))
            begin
                // drop
            end
            else if (is_digit(char_byte))
            begin
                mode_next  = MODE_NUMBER;
                point_next = 1'b0;
                recs[n]    = mk(char_byte, 1'b1, 1'b0, CLS_INT);
                n          = n + 2'd1;
            end
            else if (is_alpha(char_byte))
            begin
                mode_next = MODE_WORD;
                mask_next = match_step(9'h1FF, 3'd0, char_byte);
                len_next  = 3'd1;
                recs[n]   = mk(char_byte, 1'b1, 1'b0, CLS_INT);
                n         = n + 2'd1;
            end
            else if (char_byte == CH_QUOTE)
            begin
                mode_next = MODE_STRING;
            end
            else if (is_held_op(char_byte))
            begin
                mode_next = MODE_HELD;
                held_next = char_byte;
            end
            else if ((char_byte == "/") || (char_byte == "*"))
            begin
                recs[n] = mk(char_byte, 1'b1, 1'b1, CLS_OP);
                n       = n + 2'd1;
            end
            else
            begin
                recs[n] = mk(char_byte, 1'b1, 1'b1, CLS_SYM);
                n       = n + 2'd1;
            end
        end

        // Close whatever is open at end of source
        if (end_of_source)
        begin
            if (mode_next != MODE_IDLE)
            begin
                recs[n] = close_rec(mode_next, held_next, point_next, mask_next, len_next);
                n       = n + 2'd1;
            end
            mode_next  = MODE_IDLE;
            held_next  = 8'h00;
            point_next = 1'b0;
            mask_next  = '0;
            len_next   = '0;
        end

        // Mark the final record of this item
        if (n != 2'd0)
            recs[n - 2'd1].last = 1'b1;
    end

    assign push_cnt = accept ? n : 2'd0;

    always_comb
    begin
        for (int i = 0; i < MAX_RECS; i++)
            push_rec[i] = recs[i];
    end

    // Advance token state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            held_reg  <= 8'h00;
            point_reg <= 1'b0;
            mask_reg  <= '0;
            len_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            point_reg <= point_next;
            mask_reg  <= mask_next;
            len_reg   <= len_next;
        end
    end

endmodule

/* design/slx_queue.sv */
module slx_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_cnt,
    input  slx_pkg::rec_t push_rec [slx_pkg::MAX_RECS],
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output slx_pkg::rec_t head
);
    import slx_pkg::*;

    rec_t              entries_reg [QDEPTH];
    logic [QIDX_W-1:0] head_reg, head_next;
    logic [QIDX_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // Hold off new items unless a full burst of records fits
    assign full      = count_reg > QCNT_W'(QDEPTH - MAX_RECS);
    assign not_empty = count_reg != '0;
    assign head      = entries_reg[head_reg];

    always_comb
    begin
        head_next  = pop ? head_reg + QIDX_W'(1) : head_reg;
        tail_next  = tail_reg + QIDX_W'(push_cnt);
        count_next = count_reg + QCNT_W'(push_cnt) - QCNT_W'(pop);
    end

    // Store records at consecutive slots starting at the tail
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RECS; i++)
        begin
            if (2'(i) < push_cnt)
                entries_reg[tail_reg + QIDX_W'(i)] <= push_rec[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

/* design/script_lexer_stream.sv */
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall   char_byte, end_of_source
// output    out        out_valid/out_stall text_byte, text_valid, token_end, token_class, last
//
// One byte per cycle while in_stall is low: the lexer state and up to three records are
// computed combinationally and written into an 8-entry record queue, drained one per cycle
// while out_stall is low.
// in_stall rises while fewer than three queue slots are free.
// Reset returns the lexer to idle and empties the queue.
module script_lexer_stream (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_byte,
    input  logic       end_of_source,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] text_byte,
    output logic       text_valid,
    output logic       token_end,
    output logic [2:0] token_class,
    output logic       last
);
    import slx_pkg::*;

    logic       accept;
    logic [1:0] push_cnt;
    rec_t       push_rec [MAX_RECS];
    logic       q_full;
    rec_t       head;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    slx_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .char_byte     (char_byte),
        .end_of_source (end_of_source),
        .push_cnt      (push_cnt),
        .push_rec      (push_rec)
    );

    slx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_rec  (push_rec),
        .pop       (out_valid && !out_stall),
        .full      (q_full),
        .not_empty (out_valid),
        .head      (head)
    );

    // Present the head record
    assign text_byte   = head.text_byte;
    assign text_valid  = head.text_valid;
    assign token_end   = head.token_end;
    assign token_class = head.token_class;
    assign last        = head.last;

endmodule
